// ===== src/spmq_pkg.sv =====
package spmq_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned ID_W      = 16;
  localparam int unsigned PRIO_W    = 3;
  localparam int unsigned COUNT_W   = 10;

  // Depth of the command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;

  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_POP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [PRIO_W-1:0] level;    // already clamped to a valid level
    logic [ID_W-1:0]   task_id;
  } cmd_t;

endpackage

// ===== src/spmq_intf.sv =====
interface spmq_in_if
  import spmq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PRIO_W-1:0] priority_req;
  logic [ID_W-1:0]   task_id;

  modport source (output valid, kind, priority_req, task_id, input ready);
  modport sink   (input valid, kind, priority_req, task_id, output ready);
endinterface

interface spmq_out_if
  import spmq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_W-1:0]    popped_id;
  logic [PRIO_W-1:0]  popped_level;
  logic [COUNT_W-1:0] pending_count;

  modport source (output valid, status, popped_id, popped_level, pending_count, input ready);
  modport sink   (input valid, status, popped_id, popped_level, pending_count, output ready);
endinterface

// ===== src/strict_priority_multi_queue.sv =====
// Strict-priority multi-level task queue. NUM_LEVELS FIFOs of task ids, level 0
// highest. An add (kind 0) appends task_id to the FIFO of priority_req (levels at
// or above NUM_LEVELS go to the last level); a full level refuses the add with
// status 3. A pop (kind 1) takes the oldest id of the lowest-numbered non-empty
// level, or answers status 2 when all are empty. Every transaction in gives one
// transaction out carrying the total pending count after it. Ids are kept in
// min(ID_WIDTH,16) bits. Timing: a 2-entry command queue takes requests while the
// back end works; the back end takes no new command until the registered read of
// the single-port task memory has moved into the output register, and a stalled
// output holds it off as well. A request passes through the command queue, the
// execute stage and the output register before its result is valid. The task memory is
// not cleared at reset; per-level fill counts guard every read.
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS  = 8,
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spmq_in_if.sink    req_i,
  spmq_out_if.source rsp_o
);

  // command path from front (classify + queue) to back (execute)
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  spmq_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  spmq_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/spmq_front.sv =====
module spmq_front
  import spmq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spmq_in_if.sink   req_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i
);

  localparam int unsigned PtrW   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(CMD_DEPTH + 1);
  localparam int unsigned MaxLvl = NUM_LEVELS - 1;

  cmd_t            cmd_in;
  logic [PRIO_W:0] prio_ext;
  logic            push, pop;

  cmd_t            cmd_mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // classify: out-of-range levels fold onto the lowest priority level
  assign prio_ext = {1'b0, req_i.priority_req};

  always_comb begin
    cmd_in.kind    = kind_e'(req_i.kind);
    cmd_in.task_id = req_i.task_id;
    if (prio_ext > (PRIO_W + 1)'(MaxLvl)) begin
      cmd_in.level = PRIO_W'(MaxLvl);
    end else begin
      cmd_in.level = req_i.priority_req;
    end
  end

  assign req_i.ready = (cnt_q != CntW'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];

  assign push = req_i.valid && req_i.ready;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/spmq_back.sv =====
module spmq_back
  import spmq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS  = 8,
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  spmq_out_if.source rsp_o
);

  localparam int unsigned LW      = $clog2(NUM_LEVELS);
  localparam int unsigned PW      = $clog2(LEVEL_DEPTH);
  localparam int unsigned FW      = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned Entries = NUM_LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW      = $clog2(Entries);
  localparam int unsigned TW      = $clog2(Entries + 1);
  localparam int unsigned SW      = (ID_WIDTH < ID_W) ? ID_WIDTH : ID_W;

  // per-level bookkeeping
  logic [PW-1:0] head_q [NUM_LEVELS];
  logic [PW-1:0] tail_q [NUM_LEVELS];
  logic [FW-1:0] fill_q [NUM_LEVELS];
  logic [TW-1:0] total_q, total_d;

  // task storage, level L owns rows L*LEVEL_DEPTH onward
  logic [SW-1:0] mem_q [Entries];
  logic [SW-1:0] rd_data_q;

  // execute-to-output stage
  logic               s2_valid_q;
  status_e            s2_status_q, s2_status_d;
  logic [PRIO_W-1:0]  s2_level_q, s2_level_d;
  logic [COUNT_W-1:0] s2_count_q, s2_count_d;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [ID_W-1:0]    out_id_q;
  logic [PRIO_W-1:0]  out_level_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [NUM_LEVELS-1:0] nonempty;
  logic                  any_nonempty;
  logic [LW-1:0]         pop_lvl, add_lvl, sel_lvl;
  logic [LW+PRIO_W-1:0]  add_lvl_ext;
  logic [PW-1:0]         slot, slot_next;
  logic [AW-1:0]         addr;
  logic                  full, fire, do_add, do_pop;
  logic [TW+COUNT_W-1:0] count_ext;
  logic [LW+PRIO_W-1:0]  lvl_out_ext;
  logic [ID_W+SW-1:0]    id_ext;

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (fill_q[l] != '0);
    end
  end

  assign any_nonempty = |nonempty;

  // fixed priority: lowest level number wins
  always_comb begin
    pop_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        pop_lvl = LW'(l);
      end
    end
  end

  assign add_lvl_ext = {{LW{1'b0}}, cmd_i.level};
  assign add_lvl     = add_lvl_ext[LW-1:0];
  assign sel_lvl     = (cmd_i.kind == KIND_ADD) ? add_lvl : pop_lvl;
  assign full        = (fill_q[sel_lvl] == FW'(LEVEL_DEPTH));
  assign slot        = (cmd_i.kind == KIND_ADD) ? tail_q[sel_lvl] : head_q[sel_lvl];
  assign slot_next   = (slot == PW'(LEVEL_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign addr        = AW'(sel_lvl) * AW'(LEVEL_DEPTH) + AW'(slot);

  assign cmd_ready_o = !s2_valid_q && (!out_valid_q || rsp_o.ready);
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign do_add      = fire && (cmd_i.kind == KIND_ADD) && !full;
  assign do_pop      = fire && (cmd_i.kind == KIND_POP) && any_nonempty;

  always_comb begin
    total_d = total_q;
    if (do_add) begin
      total_d = total_q + 1'b1;
    end else if (do_pop) begin
      total_d = total_q - 1'b1;
    end
  end

  assign count_ext   = {{COUNT_W{1'b0}}, total_d};
  assign lvl_out_ext = {{PRIO_W{1'b0}}, pop_lvl};

  always_comb begin
    s2_count_d = count_ext[COUNT_W-1:0];
    s2_level_d = '0;
    if (cmd_i.kind == KIND_ADD) begin
      s2_status_d = full ? ST_FULL : ST_ADDED;
    end else if (any_nonempty) begin
      s2_status_d = ST_POPPED;
      s2_level_d  = lvl_out_ext[PRIO_W-1:0];
    end else begin
      s2_status_d = ST_EMPTY;
    end
  end

  assign id_ext = {{ID_W{1'b0}}, rd_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        fill_q[l] <= '0;
      end
      total_q     <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      total_q    <= total_d;
      s2_valid_q <= fire;
      if (do_add) begin
        tail_q[sel_lvl] <= slot_next;
        fill_q[sel_lvl] <= fill_q[sel_lvl] + 1'b1;
      end
      if (do_pop) begin
        head_q[sel_lvl] <= slot_next;
        fill_q[sel_lvl] <= fill_q[sel_lvl] - 1'b1;
      end
      if (s2_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      mem_q[addr] <= cmd_i.task_id[SW-1:0];
    end
    if (do_pop) begin
      rd_data_q <= mem_q[addr];
    end
    if (fire) begin
      s2_status_q <= s2_status_d;
      s2_level_q  <= s2_level_d;
      s2_count_q  <= s2_count_d;
    end
    if (s2_valid_q) begin
      out_status_q <= s2_status_q;
      out_level_q  <= s2_level_q;
      out_count_q  <= s2_count_q;
      out_id_q     <= (s2_status_q == ST_POPPED) ? id_ext[ID_W-1:0] : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.popped_id     = out_id_q;
  assign rsp_o.popped_level  = out_level_q;
  assign rsp_o.pending_count = out_count_q;

`ifndef SYNTHESIS
  a_s2_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> out_valid_q)
    else $error("executed transaction did not reach the output register");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(Entries))
    else $error("pending total exceeds storage");

  a_no_exec_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready && !s2_valid_q |=> !s2_valid_q)
    else $error("command executed while output stalled");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top
  import spmq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration under test; priority_req is 3 bits wide, so every
  // requested level is in range with 8 levels.
  localparam int unsigned LEVELS   = 8;
  localparam int unsigned DEPTH    = 64;
  localparam int unsigned RAND_CNT = 1300;

  // One result transaction as the scoreboard sees it
  typedef struct {
    status_e            status;
    logic [ID_W-1:0]    popped_id;
    logic [PRIO_W-1:0]  popped_level;
    logic [COUNT_W-1:0] pending_count;
  } answer_t;

  // Scoreboard: mirrors the per-level FIFOs and holds the results still owed
  class sched_scoreboard;
    logic [ID_W-1:0] task_mem [LEVELS][DEPTH];
    int unsigned     head [LEVELS];
    int unsigned     tail [LEVELS];
    int unsigned     fill [LEVELS];
    int unsigned     total;
    answer_t         owed_answers [$];
    int unsigned     errors;

    function new();
      foreach (head[l]) begin
        head[l] = 0;
        tail[l] = 0;
        fill[l] = 0;
      end
      total  = 0;
      errors = 0;
    endfunction

    // Work out the result of one accepted request and queue it
    function void apply_request(kind_e kind, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id);
      answer_t     a;
      int unsigned lvl;
      int          hit;
      a.status       = ST_ADDED;
      a.popped_id    = '0;
      a.popped_level = '0;
      if (kind == KIND_ADD) begin
        lvl = (prio >= LEVELS) ? LEVELS - 1 : prio;
        if (fill[lvl] >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          task_mem[lvl][tail[lvl]] = id;
          tail[lvl] = (tail[lvl] + 1) % DEPTH;
          fill[lvl]++;
          total++;
        end
      end else begin
        // fixed priority: lowest-numbered non-empty level wins
        hit = -1;
        for (int l = 0; l < LEVELS; l++) begin
          if (hit < 0 && fill[l] != 0) hit = l;
        end
        if (hit < 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.status       = ST_POPPED;
          a.popped_id    = task_mem[hit][head[hit]];
          a.popped_level = hit[PRIO_W-1:0];
          head[hit] = (head[hit] + 1) % DEPTH;
          fill[hit]--;
          if (total != 0) total--;
        end
      end
      a.pending_count = total[COUNT_W-1:0];
      owed_answers = {owed_answers, a};
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_answer(answer_t got);
      answer_t exp;
      if (owed_answers.size() == 0) begin
        $display("%0t: result with none owed: status %0d id %0h level %0d count %0d",
                 $time, got.status, got.popped_id, got.popped_level, got.pending_count);
        errors++;
        return;
      end
      exp = owed_answers.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.popped_id !== exp.popped_id) begin
        $display("%0t: popped_id expected %0h actual %0h", $time, exp.popped_id,
                 got.popped_id);
        errors++;
      end
      if (got.popped_level !== exp.popped_level) begin
        $display("%0t: popped_level expected %0d actual %0d", $time, exp.popped_level,
                 got.popped_level);
        errors++;
      end
      if (got.pending_count !== exp.pending_count) begin
        $display("%0t: pending_count expected %0d actual %0d", $time, exp.pending_count,
                 got.pending_count);
        errors++;
      end
    endfunction

    function int unsigned owed();
      return owed_answers.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  spmq_in_if  req_if ();
  spmq_out_if rsp_if ();

  sched_scoreboard sb = new();

  // Request transactions sent so far; a window of them runs with no idling
  int unsigned items_sent = 0;
  bit          steady     = 1'b0;

  strict_priority_multi_queue #(
    .NUM_LEVELS  (LEVELS),
    .LEVEL_DEPTH (DEPTH),
    .ID_WIDTH    (ID_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Known values on every input from time zero
  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.kind         = 1'b0;
    req_if.priority_req = '0;
    req_if.task_id      = '0;
    rsp_if.ready        = 1'b0;
  end

  // Result side backpressure: ready drops about 31% of cycles, never in the
  // steady window. Changes at the falling edge only.
  always @(negedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(99) >= 31);
  end

  // Sample result transactions at the rising edge
  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status        = status_e'(rsp_if.status);
      got.popped_id     = rsp_if.popped_id;
      got.popped_level  = rsp_if.popped_level;
      got.pending_count = rsp_if.pending_count;
      sb.check_answer(got);
    end
  end

  // Drive one request transaction. Called at a falling edge, returns at the
  // falling edge after acceptance with valid still high, so back-to-back
  // requests keep valid up without a glitch.
  task automatic send_request(kind_e kind, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id);
    steady = (items_sent >= 520 && items_sent < 800);
    while (!steady && $urandom_range(99) < 31) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.priority_req <= prio;
    req_if.task_id      <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.apply_request(kind, prio, id);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_add(logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id);
    send_request(KIND_ADD, prio, id);
  endtask

  // Pops carry random junk in the ignored fields
  task automatic pop_task();
    send_request(KIND_POP, PRIO_W'($urandom_range(7)), ID_W'($urandom_range(16'hFFFF)));
  endtask

  // Id mix: mostly random, some at the extremes
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ID_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned lvl;
    int unsigned cycles;
    int unsigned rand_start;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ---
    pop_task();                       // pop with every level empty
    send_add(3'd7, 16'h0000);         // extremes of level and id
    send_add(3'd0, 16'hFFFF);
    send_add(3'd3, 16'h5A5A);         // two on one level: FIFO order
    send_add(3'd3, 16'hA5A5);
    send_add(3'd1, 16'h0001);
    send_add(3'd2, 16'h8000);
    send_add(3'd4, 16'h1234);
    send_add(3'd5, 16'hFEDC);
    send_add(3'd6, 16'h7FFF);
    // drain in strict priority order, then one more pop hits empty again
    repeat (10) pop_task();

    // --- random ---
    // Segments: bursts of adds on one level that can run past full (refusals, pointer
    // wrap), drain bursts, add-heavy and balanced mixes.
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_CNT) begin
      mode = $urandom_range(9);
      case (mode)
        0, 1: begin
          lvl = $urandom_range(LEVELS - 1);
          len = $urandom_range(72, 60);
          repeat (len) send_add(PRIO_W'(lvl), pick_id());
        end
        2: begin
          len = $urandom_range(80, 30);
          repeat (len) pop_task();
        end
        3, 4, 5: begin
          len = $urandom_range(60, 20);
          repeat (len) begin
            if ($urandom_range(99) < 75) send_add(PRIO_W'($urandom_range(7)), pick_id());
            else pop_task();
          end
        end
        default: begin
          len = $urandom_range(60, 20);
          repeat (len) begin
            if ($urandom_range(1) == 0) send_add(PRIO_W'($urandom_range(7)), pick_id());
            else pop_task();
          end
        end
      endcase
    end
    req_if.valid <= 1'b0;
    steady = 1'b0;

    // Let owed results drain, with a bound, then check that none are left
    cycles = 0;
    while (sb.owed() != 0 && cycles < 5000) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.owed() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.owed());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
